// ----- hw/rtl/aes128_block_cipher_assert.svh -----
// Assertion macros shared by the AES-128 RTL.
// No dependencies.
`ifndef AES128_BLOCK_CIPHER_ASSERT_SVH
`define AES128_BLOCK_CIPHER_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication checked outside reset.
`define AES_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ----- hw/rtl/aes_pkg.sv -----
// Types, tables and round functions for the AES-128 block cipher.
// No dependencies.
package aes_pkg;

	typedef struct packed {
		logic        kind;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} out_item_t;

	localparam logic [0:0] KIND_ENC = 1'b0;
	localparam logic [0:0] KIND_DEC = 1'b1;
	localparam logic [0:0] REG_KEY_HIGH = 1'b0;
	localparam logic [0:0] REG_KEY_LOW  = 1'b1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [7:0] SBOX_INV [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	localparam logic [7:0] RCON [10] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

	// byte i of the state sits at bits [127-8i -: 8]
	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		for (int i = 0; i < 16; i++)
			t[127 - 8 * i -: 8] = inv ? SBOX_INV[s[127 - 8 * i -: 8]] : SBOX[s[127 - 8 * i -: 8]];
		sub_bytes = t;
	endfunction

	function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic left);
		logic [127:0] t;
		int src;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				src = left ? ((c + r) & 3) : ((c - r + 4) & 3);
				t[127 - 8 * (4 * c + r) -: 8] = s[127 - 8 * (4 * src + r) -: 8];
			end
		shift_rows = t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		logic [7:0] a0, a1, a2, a3, u, v, t;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32 * c -: 8];
			a1 = s[119 - 32 * c -: 8];
			a2 = s[111 - 32 * c -: 8];
			a3 = s[103 - 32 * c -: 8];
			if (inv) begin
				u = xtime(xtime(a0 ^ a2));
				v = xtime(xtime(a1 ^ a3));
				a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
			end
			t = a0 ^ a1 ^ a2 ^ a3;
			o[127 - 32 * c -: 8] = xtime(a0 ^ a1) ^ a0 ^ t;
			o[119 - 32 * c -: 8] = xtime(a1 ^ a2) ^ a1 ^ t;
			o[111 - 32 * c -: 8] = xtime(a2 ^ a3) ^ a2 ^ t;
			o[103 - 32 * c -: 8] = xtime(a3 ^ a0) ^ a3 ^ t;
		end
		mix_columns = o;
	endfunction

endpackage

// ----- hw/rtl/aes128_block_cipher.sv -----
// AES-128 block cipher top level: key schedule sequencer and shared round unit.
// Depends on aes_pkg and aes128_block_cipher_assert.svh.
//
// channel | dir | handshake              | payload
// cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (key_high, key_low)
// in      | in  | in_valid / in_ready    | aes_pkg::in_item_t
// out     | out | out_valid / out_ready  | aes_pkg::out_item_t
//
// A block runs through the round unit as the initial key add and then ten
// rounds, and the result is then loaded into the output register. The one
// shared round unit takes no new block until that result has left it. After reset
// or a key write the schedule is expanded one round key per cycle, during
// which in_ready is low. The result waits in the output register; a
// stalled out channel holds the next block only once that block has finished.
module aes128_block_cipher #(
	parameter int ROUNDS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  aes_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output aes_pkg::out_item_t  out_data
);
	`include "aes128_block_cipher_assert.svh"

	localparam int RW = $clog2(ROUNDS + 1);

	typedef enum logic [1:0] {ST_EXPAND, ST_IDLE, ST_RUN, ST_DONE} state_t;

	state_t             state_q;
	logic [127:0]       key_q;
	logic [127:0]       rk_mem [ROUNDS + 1];
	logic [127:0]       exp_q;
	logic [RW-1:0]      cnt_q;
	logic [RW-1:0]      rd_idx;
	logic [127:0]       rk_rd_q;
	logic [127:0]       blk_q;
	logic               dec_q;
	logic [127:0]       next_key;
	logic [127:0]       round_out;
	logic [127:0]       t0;
	logic               last_round;
	aes_pkg::out_item_t out_q;
	logic               out_vld_q;
	logic               out_load;

	// key expansion, one round key per cycle
	always_comb begin
		logic [31:0] tw, w0, w1, w2, w3;
		tw = aes_pkg::sub_word({exp_q[23:0], exp_q[31:24]})
			^ {aes_pkg::RCON[cnt_q], 24'h0};
		w0 = exp_q[127:96] ^ tw;
		w1 = exp_q[95:64] ^ w0;
		w2 = exp_q[63:32] ^ w1;
		w3 = exp_q[31:0] ^ w2;
		next_key = {w0, w1, w2, w3};
	end

	// shared round unit; cnt_q is the round number being applied
	assign last_round = (cnt_q == RW'(ROUNDS));
	always_comb begin
		if (dec_q == aes_pkg::KIND_DEC) begin
			t0 = aes_pkg::sub_bytes(aes_pkg::shift_rows(blk_q, 1'b0), 1'b1) ^ rk_rd_q;
			round_out = last_round ? t0 : aes_pkg::mix_columns(t0, 1'b1);
		end else begin
			t0 = aes_pkg::shift_rows(aes_pkg::sub_bytes(blk_q, 1'b0), 1'b1);
			round_out = (last_round ? t0 : aes_pkg::mix_columns(t0, 1'b0)) ^ rk_rd_q;
		end
	end

	// round key read address for the next cycle's round
	always_comb begin
		if (state_q == ST_IDLE)
			rd_idx = in_data.kind ? RW'(ROUNDS) : '0;
		else
			rd_idx = dec_q ? RW'(ROUNDS) - cnt_q - RW'(1) : cnt_q + RW'(1);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXPAND)
			rk_mem[cnt_q] <= exp_q;
		if (state_q == ST_IDLE || state_q == ST_RUN)
			rk_rd_q <= rk_mem[rd_idx];
	end

	assign out_load  = (state_q == ST_DONE) && (!out_vld_q || out_ready);
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_EXPAND;
			key_q     <= '0;
			exp_q     <= '0;
			cnt_q     <= '0;
			dec_q     <= 1'b0;
			blk_q     <= '0;
			out_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_q     <= {blk_q[127:64], blk_q[63:0]};
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_EXPAND: begin
					if (cnt_q == RW'(ROUNDS)) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + RW'(1);
						exp_q <= next_key;
					end
				end
				ST_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == aes_pkg::REG_KEY_HIGH) begin
							key_q[127:64] <= cfg_data;
							exp_q <= {cfg_data, key_q[63:0]};
						end else begin
							key_q[63:0] <= cfg_data;
							exp_q <= {key_q[127:64], cfg_data};
						end
						state_q <= ST_EXPAND;
						cnt_q   <= '0;
					end else if (in_valid) begin
						blk_q   <= {in_data.block_high, in_data.block_low};
						dec_q   <= in_data.kind;
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cnt_q == '0)
						blk_q <= blk_q ^ rk_rd_q;
					else
						blk_q <= round_out;
					if (last_round)
						state_q <= ST_DONE;
					else
						cnt_q <= cnt_q + RW'(1);
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end
				end
				default: state_q <= ST_EXPAND;
			endcase
		end
	end

	`AES_ASSERT_IMP(a_no_in_busy, clk, arst_n, state_q != ST_IDLE, !in_ready, "input taken while busy")
	`AES_ASSERT_NXT(a_run_to_done, clk, arst_n, state_q == ST_RUN && last_round, state_q == ST_DONE, "round count overran")
	`AES_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
	`AES_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= RW'(ROUNDS), "round counter out of range")

endmodule
